// File: design/frie_pkg.sv
package frie_pkg;

  // Default sizing of the register file and data memory
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned MemDepthDef  = 256;

  // Fixed field widths
  localparam int unsigned PcW       = 16;
  localparam int unsigned InstrW    = 16;
  localparam int unsigned LdAddrW   = 8;
  localparam int unsigned LdDataW   = 16;
  localparam int unsigned StatW     = 2;
  localparam int unsigned RegAw     = 2;
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned InAddrW   = 8;
  localparam int unsigned STdataW   = 40;
  localparam int unsigned MTdataW   = 40;

  // Instruction opcodes
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_AND   = 4'd3,
    OP_NOT   = 4'd4,
    OP_INC   = 4'd5,
    OP_DEC   = 4'd6,
    OP_LDI   = 4'd7,
    OP_LD    = 4'd8,
    OP_ST    = 4'd9,
    OP_JMP   = 4'd10,
    OP_JNE   = 4'd11,
    OP_IN    = 4'd12,
    OP_OUT   = 4'd13,
    OP_HALT  = 4'd14,
    OP_HALT2 = 4'd15
  } opcode_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_CONT  = 2'd0,
    ST_DONE  = 2'd1,
    ST_BLOCK = 2'd2
  } status_e;

endpackage

// File: design/frie_ram.sv
module frie_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/four_register_instruction_executor.sv
// Channel   Direction  Fields
// s_axis    in         tuser: op; tdata: instr, load_addr, load_data
// m_axis    out        tdata: status, next_pc, dest_value
//
// One transaction per cycle sustained while the output is not stalled. An item first reads the
// data memory and both register-file copies, then executes and writes back in the
// execute stage; the last write is forwarded to the item right behind it.
// Reset clears the program counter and the valid bits of the register file
// and data memory (unwritten entries read as zero); no clearing pass.
// A stalled output holds the execute stage, which stops intake.
module four_register_instruction_executor
  import frie_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned MEM_DEPTH  = MemDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STdataW-1:0] s_axis_tdata,  // instr[15:0], load_addr[23:16], load_data[39:24]
  input  logic               s_axis_tuser,  // op[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MTdataW-1:0] m_axis_tdata   // status[1:0], next_pc[17:2], dest_value[33:18]
);

  localparam int unsigned Aw    = $clog2(MEM_DEPTH);
  localparam int unsigned Recip = (65536 + MEM_DEPTH - 1) / MEM_DEPTH;

  // Reduce an 8-bit address modulo the memory depth (exact reciprocal)
  function automatic logic [Aw-1:0] mem_idx(input logic [InAddrW-1:0] a);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [15:0] back;
    logic [7:0]  rem;
    prod = 24'(a) * 24'(Recip);
    quo  = prod[23:16];
    back = 16'(quo) * 16'(MEM_DEPTH);
    rem  = a - back[7:0];
    return rem[Aw-1:0];
  endfunction

  // Input unpacking
  logic [InstrW-1:0]  in_instr;
  logic [LdAddrW-1:0] in_ld_addr;
  logic [LdDataW-1:0] in_ld_data;
  logic               s_fire;
  logic [Aw-1:0]      in_ma;
  logic [Aw-1:0]      in_la;
  logic [RegAw-1:0]   in_src;
  logic [RegAw-1:0]   in_dst;

  assign in_instr   = s_axis_tdata[15:0];
  assign in_ld_addr = s_axis_tdata[23:16];
  assign in_ld_data = s_axis_tdata[39:24];
  assign in_src     = in_instr[11:10];
  assign in_dst     = in_instr[9:8];
  assign in_ma      = mem_idx(in_instr[7:0]);
  assign in_la      = mem_idx(in_ld_addr);
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  // Execute stage registers
  logic               s1_valid_q;
  logic               s1_op_q;
  logic [InstrW-1:0]  s1_instr_q;
  logic [Aw-1:0]      s1_ma_q;
  logic [Aw-1:0]      s1_la_q;
  logic [LdDataW-1:0] s1_ld_data_q;
  logic               s1_mvld_q;
  logic               s1_svld_q;
  logic               s1_dvld_q;

  // Architectural state and bypass
  logic [PcW-1:0]        pc_q, pc_d;
  logic [MEM_DEPTH-1:0]  mem_vld_q;
  logic [NumRegs-1:0]    reg_vld_q;
  logic                  mbp_vld_q;
  logic [Aw-1:0]         mbp_addr_q;
  logic [DATA_WIDTH-1:0] mbp_data_q;
  logic                  rbp_vld_q;
  logic [RegAw-1:0]      rbp_addr_q;
  logic [DATA_WIDTH-1:0] rbp_data_q;

  // Output register
  logic               m_valid_q;
  logic [MTdataW-1:0] m_data_q, m_data_d;

  // Write-back controls
  logic                  s1_go;
  logic                  mem_we;
  logic [Aw-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  reg_we;
  logic [DATA_WIDTH-1:0] reg_wdata;
  status_e               status;

  // Read data
  logic [DATA_WIDTH-1:0] mem_dout, src_dout, dst_dout;
  logic [DATA_WIDTH-1:0] mem_rd, src_val, dst_val, dest_out;
  logic [RegAw-1:0]      s1_src, s1_dst;
  opcode_e               s1_opc;

  assign s1_src = s1_instr_q[11:10];
  assign s1_dst = s1_instr_q[9:8];
  assign s1_opc = opcode_e'(s1_instr_q[15:12]);

  assign s1_go         = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;

  // Data memory
  frie_ram #(
    .Width (DATA_WIDTH),
    .Depth (MEM_DEPTH)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we && s1_go),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (s_fire),
    .raddr_i (in_ma),
    .rdata_o (mem_dout)
  );

  // Register file, source-port copy
  frie_ram #(
    .Width (DATA_WIDTH),
    .Depth (NumRegs)
  ) u_rf_src (
    .clk_i   (clk_i),
    .we_i    (reg_we && s1_go),
    .waddr_i (s1_dst),
    .wdata_i (reg_wdata),
    .re_i    (s_fire),
    .raddr_i (in_src),
    .rdata_o (src_dout)
  );

  // Register file, destination-port copy
  frie_ram #(
    .Width (DATA_WIDTH),
    .Depth (NumRegs)
  ) u_rf_dst (
    .clk_i   (clk_i),
    .we_i    (reg_we && s1_go),
    .waddr_i (s1_dst),
    .wdata_i (reg_wdata),
    .re_i    (s_fire),
    .raddr_i (in_dst),
    .rdata_o (dst_dout)
  );

  // Resolve operands: last write first, then unwritten entries as zero
  always_comb begin
    if (mbp_vld_q && (mbp_addr_q == s1_ma_q)) begin
      mem_rd = mbp_data_q;
    end else begin
      mem_rd = s1_mvld_q ? mem_dout : '0;
    end
    if (rbp_vld_q && (rbp_addr_q == s1_src)) begin
      src_val = rbp_data_q;
    end else begin
      src_val = s1_svld_q ? src_dout : '0;
    end
    if (rbp_vld_q && (rbp_addr_q == s1_dst)) begin
      dst_val = rbp_data_q;
    end else begin
      dst_val = s1_dvld_q ? dst_dout : '0;
    end
  end

  // Execute
  always_comb begin
    pc_d      = pc_q;
    mem_we    = 1'b0;
    mem_waddr = s1_ma_q;
    mem_wdata = src_val;
    reg_we    = 1'b0;
    reg_wdata = dst_val;
    status    = ST_CONT;
    if (s1_op_q) begin
      mem_we    = 1'b1;
      mem_waddr = s1_la_q;
      mem_wdata = DATA_WIDTH'(s1_ld_data_q);
    end else begin
      pc_d = pc_q + PcW'(1);
      case (s1_opc)
        OP_NOP: ;
        OP_ADD: begin
          reg_we    = 1'b1;
          reg_wdata = dst_val + src_val;
        end
        OP_SUB: begin
          reg_we    = 1'b1;
          reg_wdata = dst_val - src_val;
        end
        OP_AND: begin
          reg_we    = 1'b1;
          reg_wdata = dst_val & src_val;
        end
        OP_NOT: begin
          reg_we    = 1'b1;
          reg_wdata = ~src_val;
        end
        OP_INC: begin
          reg_we    = 1'b1;
          reg_wdata = src_val + DATA_WIDTH'(1);
        end
        OP_DEC: begin
          reg_we    = 1'b1;
          reg_wdata = src_val - DATA_WIDTH'(1);
        end
        OP_LDI: begin
          reg_we    = 1'b1;
          reg_wdata = DATA_WIDTH'(s1_instr_q[7:0]);
        end
        OP_LD: begin
          reg_we    = 1'b1;
          reg_wdata = mem_rd;
        end
        OP_ST: begin
          mem_we = 1'b1;
        end
        OP_JMP: begin
          pc_d = PcW'(mem_rd);
        end
        OP_JNE: begin
          if (dst_val != src_val) begin
            pc_d = PcW'(mem_rd);
          end
        end
        OP_IN, OP_OUT: begin
          status = ST_BLOCK;
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
    dest_out = reg_we ? reg_wdata : dst_val;
    m_data_d = {6'b0, 16'(dest_out), pc_d, status};
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      pc_q       <= '0;
      mem_vld_q  <= '0;
      reg_vld_q  <= '0;
      mbp_vld_q  <= 1'b0;
      rbp_vld_q  <= 1'b0;
    end else begin
      // advance the execute stage
      if (s_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      // hold the result until taken
      if (s1_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (s1_go) begin
        pc_q <= pc_d;
        if (mem_we) begin
          mem_vld_q[mem_waddr] <= 1'b1;
          mbp_vld_q            <= 1'b1;
        end
        if (reg_we) begin
          reg_vld_q[s1_dst] <= 1'b1;
          rbp_vld_q         <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_op_q      <= s_axis_tuser;
      s1_instr_q   <= in_instr;
      s1_ma_q      <= in_ma;
      s1_la_q      <= in_la;
      s1_ld_data_q <= in_ld_data;
      s1_mvld_q    <= mem_vld_q[in_ma];
      s1_svld_q    <= reg_vld_q[in_src];
      s1_dvld_q    <= reg_vld_q[in_dst];
    end
    if (s1_go) begin
      m_data_q <= m_data_d;
      if (mem_we) begin
        mbp_addr_q <= mem_waddr;
        mbp_data_q <= mem_wdata;
      end
      if (reg_we) begin
        rbp_addr_q <= s1_dst;
        rbp_data_q <= reg_wdata;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: verif/tb_four_register_instruction_executor.sv
// Expected outcome of one executed or memory-write item
typedef struct packed {
  frie_pkg::status_e  status;
  logic [15:0]        next_pc;
  logic [15:0]        dest_value;
} exec_outcome_t;

// Tracks architectural state and the outcomes still owed by the block
class exec_state_tracker;
  logic [15:0]   gp[4];
  logic [15:0]   pc;
  logic [15:0]   dmem[256];
  exec_outcome_t owed[$];
  int unsigned   n_fail;

  function new();
    foreach (gp[i]) gp[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc     = '0;
    n_fail = 0;
  endfunction

  function int unsigned pending();
    return owed.size();
  endfunction

  // Advance the state by one accepted item and queue its outcome
  function void note_item(logic op, logic [15:0] instr, logic [7:0] ld_addr,
                          logic [15:0] ld_data);
    frie_pkg::opcode_e opc;
    logic [1:0]        rs;
    logic [1:0]        rd;
    logic [7:0]        ad;
    exec_outcome_t     res;
    opc        = frie_pkg::opcode_e'(instr[15:12]);
    rs         = instr[11:10];
    rd         = instr[9:8];
    ad         = instr[7:0];
    res.status = frie_pkg::ST_CONT;
    if (op) begin
      dmem[ld_addr] = ld_data;
    end else begin
      pc = pc + 16'd1;
      case (opc)
        frie_pkg::OP_NOP:   ;
        frie_pkg::OP_ADD:   gp[rd] = gp[rd] + gp[rs];
        frie_pkg::OP_SUB:   gp[rd] = gp[rd] - gp[rs];
        frie_pkg::OP_AND:   gp[rd] = gp[rd] & gp[rs];
        frie_pkg::OP_NOT:   gp[rd] = ~gp[rs];
        frie_pkg::OP_INC:   gp[rd] = gp[rs] + 16'd1;
        frie_pkg::OP_DEC:   gp[rd] = gp[rs] - 16'd1;
        frie_pkg::OP_LDI:   gp[rd] = {8'd0, ad};
        frie_pkg::OP_LD:    gp[rd] = dmem[ad];
        frie_pkg::OP_ST:    dmem[ad] = gp[rs];
        frie_pkg::OP_JMP:   pc = dmem[ad];
        frie_pkg::OP_JNE: begin
          if (gp[rd] != gp[rs]) pc = dmem[ad];
        end
        frie_pkg::OP_IN, frie_pkg::OP_OUT: res.status = frie_pkg::ST_BLOCK;
        default:            res.status = frie_pkg::ST_DONE;
      endcase
    end
    res.next_pc    = pc;
    res.dest_value = gp[rd];
    owed.push_back(res);
  endfunction

  // Compare one result transaction against the oldest owed outcome
  function void check_result(logic [39:0] tdata);
    exec_outcome_t want;
    if (owed.size() == 0) begin
      $error("result with nothing outstanding: tdata=%h", tdata);
      n_fail++;
      return;
    end
    want = owed.pop_front();
    if (tdata[1:0] != want.status) begin
      $error("status: expected %0d, got %0d", want.status, tdata[1:0]);
      n_fail++;
    end
    if (tdata[17:2] != want.next_pc) begin
      $error("next_pc: expected %h, got %h", want.next_pc, tdata[17:2]);
      n_fail++;
    end
    if (tdata[33:18] != want.dest_value) begin
      $error("dest_value: expected %h, got %h", want.dest_value, tdata[33:18]);
      n_fail++;
    end
  endfunction
endclass

module tb_four_register_instruction_executor;
  timeunit 1ns;
  timeprecision 1ps;
  import frie_pkg::*;

  localparam int unsigned NumItems  = 450;
  localparam int unsigned CalmItems = 80;
  localparam int unsigned StallMax  = 1000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [MTdataW-1:0] m_axis_tdata;

  exec_state_tracker  tracker;
  bit                 calm;
  int unsigned        idle_cycles;

  four_register_instruction_executor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [15:0] mk_instr(opcode_e opc, logic [1:0] rs, logic [1:0] rd,
                                           logic [7:0] ad);
    return {opc, rs, rd, ad};
  endfunction

  // Drive one input transaction, with an optional idle burst ahead of it
  task automatic send_item(logic op, logic [15:0] instr, logic [7:0] ld_addr,
                           logic [15:0] ld_data);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {ld_data, ld_addr, instr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every owed outcome has arrived
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Monitor both channels and count cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                          s_axis_tdata[39:24]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallMax) begin
          $display("four_register_instruction_executor test failed");
          $finish;
        end
      end
    end
  end

  // Receiver: ready with random stall bursts, none in the calm phase
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] instr;
    logic [7:0]  ad;
    tracker       = new();
    calm          = 1'b0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every opcode, wraparound, forwarding, jumps and pc wrap
    send_item(1'b0, mk_instr(OP_NOP, 2'd0, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_LDI, 2'd0, 2'd0, 8'hff), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_LDI, 2'd0, 2'd1, 8'h01), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_ADD, 2'd1, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_NOT, 2'd3, 2'd2, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_INC, 2'd2, 2'd3, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_DEC, 2'd3, 2'd3, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_SUB, 2'd2, 2'd1, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_AND, 2'd0, 2'd2, 8'h00), 8'h00, 16'h0000);
    send_item(1'b1, mk_instr(OP_NOP, 2'd0, 2'd3, 8'h00), 8'hff, 16'hffff);
    send_item(1'b0, mk_instr(OP_LD,  2'd0, 2'd1, 8'hff), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_ST,  2'd2, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_LD,  2'd0, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_JMP, 2'd0, 2'd0, 8'hff), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_NOP, 2'd0, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_JNE, 2'd0, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_JNE, 2'd1, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_IN,  2'd0, 2'd1, 8'h12), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_OUT, 2'd1, 2'd2, 8'h34), 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_HALT, 2'd2, 2'd3, 8'h00), 8'h00, 16'h0000);
    send_item(1'b0, 16'hffff, 8'h00, 16'h0000);
    send_item(1'b0, mk_instr(OP_NOP, 2'd0, 2'd0, 8'h00), 8'h00, 16'h0000);
    send_item(1'b1, 16'hffff, 8'h00, 16'h0000);
    drain();
    @(negedge clk_i);

    // Random: memory writes mixed with instructions, addresses often clustered
    for (int i = 0; i < NumItems; i++) begin
      calm = (i >= NumItems - CalmItems);
      if (i == NumItems / 3 || i == 2 * NumItems / 3) drain();
      ad    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      instr = {4'($urandom), 4'($urandom), ad};
      if ($urandom_range(0, 3) == 0)
        send_item(1'b1, instr, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                           : 8'($urandom),
                  16'($urandom));
      else
        send_item(1'b0, instr, 8'($urandom), 16'($urandom));
    end
    s_axis_tvalid = 1'b0;

    // Wait for the last outcomes, then keep watching for stray results
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (tracker.n_fail == 0) begin
      $display("four_register_instruction_executor test passed");
    end else begin
      $display("four_register_instruction_executor test failed");
    end
    $finish;
  end

endmodule
